FILE: rtl/core/orbital_frame_rotation_assert.svh
// Assertion macros used by the orbital frame rotation checker
`ifndef ORBITAL_FRAME_ROTATION_ASSERT_SVH
`define ORBITAL_FRAME_ROTATION_ASSERT_SVH

// Check a consequent in the same cycle as its antecedent
`define OFR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequent in the cycle after its antecedent
`define OFR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/ofr_pkg.sv
// Shared types, constants and tables for the orbital frame rotation
package ofr_pkg;

  // default parameter values
  localparam int unsigned AngleBitsDef = 16;
  localparam int unsigned DataBitsDef  = 32;
  localparam int unsigned TrigIterDef  = 18;

  // register indexes
  localparam logic [1:0] CfgNode      = 2'd0;
  localparam logic [1:0] CfgPeriapsis = 2'd1;
  localparam logic [1:0] CfgIncl      = 2'd2;

  // CORDIC start value (reciprocal of the gain, Q1.30)
  localparam logic signed [33:0] CordicX0 = 34'sd652032874;
  localparam logic signed [33:0] OneQ30   = 34'sd1073741824;

  typedef logic signed [32:0] entry_t;
  typedef entry_t [2:0][2:0] matrix_t;

  // word travelling along the CORDIC cell row
  typedef struct packed {
    logic              valid;
    logic              flip;
    logic [1:0]        sel;
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [33:0] z;
  } cordic_t;

  // product steps of the matrix build
  typedef enum logic [3:0] {
    OP_P1, OP_P2, OP_P3, OP_P4,
    OP_Q1, OP_Q2, OP_Q3, OP_Q4,
    OP_E02, OP_E12, OP_E20, OP_E21
  } op_e;

  typedef enum logic [2:0] {
    MG_IDLE, MG_FEED, MG_WAIT, MG_MUL, MG_SUM
  } mg_state_e;

  // arctangent of 2^-i in 2^32 units per turn
  function automatic logic [31:0] atan_turns(input int unsigned i);
    logic [31:0] r;
    case (i)
      0:  r = 32'd536870912;
      1:  r = 32'd316933406;
      2:  r = 32'd167458907;
      3:  r = 32'd85004756;
      4:  r = 32'd42667331;
      5:  r = 32'd21354465;
      6:  r = 32'd10680862;
      7:  r = 32'd5340245;
      8:  r = 32'd2670163;
      9:  r = 32'd1335087;
      10: r = 32'd667544;
      11: r = 32'd333772;
      12: r = 32'd166886;
      13: r = 32'd83443;
      14: r = 32'd41721;
      15: r = 32'd20861;
      16: r = 32'd10430;
      17: r = 32'd5215;
      18: r = 32'd2608;
      19: r = 32'd1304;
      20: r = 32'd652;
      21: r = 32'd326;
      22: r = 32'd163;
      23: r = 32'd81;
      24: r = 32'd41;
      25: r = 32'd20;
      26: r = 32'd10;
      27: r = 32'd5;
      28: r = 32'd3;
      29: r = 32'd1;
      30: r = 32'd1;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/core/orbital_frame_rotation.sv
// Top level: 3-1-3 Euler frame rotation of a stream of vectors
// An accepted word passes product, sum and accumulator registers to the output register.
// Throughput: one word per cycle when input is not stalled; every stage takes a new word
// each cycle while the skid register is empty. A one-word skid register behind the output
// register absorbs a stall that meets a full pipeline. A register write rebuilds the
// matrix through the CORDIC cell row and one shared multiplier while input is stalled.
module orbital_frame_rotation #(
  parameter int unsigned ANGLE_BITS      = ofr_pkg::AngleBitsDef,
  parameter int unsigned DATA_BITS       = ofr_pkg::DataBitsDef,
  parameter int unsigned TRIG_ITERATIONS = ofr_pkg::TrigIterDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [1:0]                  cfg_index_i,
  input  logic [ANGLE_BITS-1:0]       cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic signed [DATA_BITS-1:0] vec_x_i,
  input  logic signed [DATA_BITS-1:0] vec_y_i,
  input  logic signed [DATA_BITS-1:0] vec_z_i,
  input  logic                        operation_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic signed [DATA_BITS-1:0] out_x_o,
  output logic signed [DATA_BITS-1:0] out_y_o,
  output logic signed [DATA_BITS-1:0] out_z_o,
  output logic                        saturated_o
);
  import ofr_pkg::*;

  logic    busy;
  matrix_t matrix;

  // build the matrix from the angle registers
  ofr_matrix_gen #(
    .ANGLE_BITS      (ANGLE_BITS),
    .TRIG_ITERATIONS (TRIG_ITERATIONS)
  ) u_matrix (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .busy_o      (busy),
    .matrix_o    (matrix)
  );

  // rotate each word
  ofr_rotate_pipe #(
    .DATA_BITS (DATA_BITS)
  ) u_pipe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .matrix_i    (matrix),
    .hold_i      (busy),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .vec_x_i     (vec_x_i),
    .vec_y_i     (vec_y_i),
    .vec_z_i     (vec_z_i),
    .operation_i (operation_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_x_o     (out_x_o),
    .out_y_o     (out_y_o),
    .out_z_o     (out_z_o),
    .saturated_o (saturated_o)
  );

endmodule

FILE: rtl/core/ofr_cordic_cell.sv
// One rotation-mode CORDIC cell of the sine/cosine row
module ofr_cordic_cell #(
  parameter int unsigned STEP = 0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ofr_pkg::cordic_t cell_i,
  output ofr_pkg::cordic_t cell_o
);
  import ofr_pkg::*;

  localparam logic [31:0] Atan = atan_turns(STEP);

  logic signed [33:0] dx, dy;
  logic               valid_q;
  cordic_t            cell_d, data_q;

  // rotate towards zero residual angle
  always_comb begin
    dx = cell_i.y >>> STEP;
    dy = cell_i.x >>> STEP;
    cell_d = cell_i;
    if (!cell_i.z[33]) begin
      cell_d.x = cell_i.x - dx;
      cell_d.y = cell_i.y + dy;
      cell_d.z = cell_i.z - $signed({2'b00, Atan});
    end else begin
      cell_d.x = cell_i.x + dx;
      cell_d.y = cell_i.y - dy;
      cell_d.z = cell_i.z + $signed({2'b00, Atan});
    end
  end

  // hand the word on every cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= cell_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= cell_d;
  end

  always_comb begin
    cell_o       = data_q;
    cell_o.valid = valid_q;
  end

endmodule

FILE: rtl/core/ofr_matrix_gen.sv
// Angle registers, sine/cosine cell row and direction cosine matrix build
module ofr_matrix_gen #(
  parameter int unsigned ANGLE_BITS      = ofr_pkg::AngleBitsDef,
  parameter int unsigned TRIG_ITERATIONS = ofr_pkg::TrigIterDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [1:0]            cfg_index_i,
  input  logic [ANGLE_BITS-1:0] cfg_data_i,
  output logic                  busy_o,
  output ofr_pkg::matrix_t      matrix_o
);
  import ofr_pkg::*;

  localparam int unsigned Shift = 32 - ANGLE_BITS;

  logic [ANGLE_BITS-1:0] ang_q [3];
  logic                  dirty_q, dirty_d;
  mg_state_e             state_q, state_d;
  logic [1:0]            feed_q, feed_d;
  op_e                   op_q, op_d;

  logic [ANGLE_BITS-1:0] ang_sel;
  logic [31:0]           a32, a32f;
  logic                  flip;
  cordic_t               chain [TRIG_ITERATIONS+1];

  logic signed [33:0] xo, yo;
  logic signed [31:0] cos_v, sin_v;
  logic signed [31:0] sin_q [3];
  logic signed [31:0] cos_q [3];
  logic signed [31:0] slot_q [12];

  logic signed [31:0] opa, opb;
  logic signed [63:0] prod, prod_r;
  matrix_t            mat_q;

  // hold the angle registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ang_q[0] <= '0;
      ang_q[1] <= '0;
      ang_q[2] <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgNode:      ang_q[0] <= cfg_data_i;
        CfgPeriapsis: ang_q[1] <= cfg_data_i;
        CfgIncl:      ang_q[2] <= cfg_data_i;
        default:      ;
      endcase
    end
  end

  // fold the angle into the right half plane
  always_comb begin
    case (feed_q)
      2'd0:    ang_sel = ang_q[0];
      2'd1:    ang_sel = ang_q[1];
      default: ang_sel = ang_q[2];
    endcase
    a32  = 32'(ang_sel) << Shift;
    flip = (a32[31:30] == 2'b01) || (a32[31:30] == 2'b10);
    a32f = flip ? (a32 ^ 32'h8000_0000) : a32;
  end

  always_comb begin
    chain[0].valid = (state_q == MG_FEED);
    chain[0].flip  = flip;
    chain[0].sel   = feed_q;
    chain[0].x     = CordicX0;
    chain[0].y     = '0;
    chain[0].z     = 34'($signed(a32f));
  end

  // row of CORDIC cells, one step each
  for (genvar i = 0; i < TRIG_ITERATIONS; i++) begin : g_cell
    ofr_cordic_cell #(.STEP(i)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cell_i (chain[i]),
      .cell_o (chain[i+1])
    );
  end

  // undo the fold and clamp to one
  always_comb begin
    xo = chain[TRIG_ITERATIONS].flip ? -chain[TRIG_ITERATIONS].x : chain[TRIG_ITERATIONS].x;
    yo = chain[TRIG_ITERATIONS].flip ? -chain[TRIG_ITERATIONS].y : chain[TRIG_ITERATIONS].y;
    if (xo > OneQ30)       cos_v = 32'(OneQ30);
    else if (xo < -OneQ30) cos_v = 32'(-OneQ30);
    else                   cos_v = 32'(xo);
    if (yo > OneQ30)       sin_v = 32'(OneQ30);
    else if (yo < -OneQ30) sin_v = 32'(-OneQ30);
    else                   sin_v = 32'(yo);
  end

  always_ff @(posedge clk_i) begin
    if (chain[TRIG_ITERATIONS].valid) begin
      sin_q[chain[TRIG_ITERATIONS].sel] <= sin_v;
      cos_q[chain[TRIG_ITERATIONS].sel] <= cos_v;
    end
  end

  // pick the operands of the current product step
  always_comb begin
    case (op_q)
      OP_P1:   begin opa = cos_q[0];            opb = cos_q[1]; end
      OP_P2:   begin opa = sin_q[0];            opb = sin_q[1]; end
      OP_P3:   begin opa = sin_q[0];            opb = cos_q[1]; end
      OP_P4:   begin opa = cos_q[0];            opb = sin_q[1]; end
      OP_Q1:   begin opa = slot_q[OP_P1];       opb = cos_q[2]; end
      OP_Q2:   begin opa = slot_q[OP_P2];       opb = cos_q[2]; end
      OP_Q3:   begin opa = slot_q[OP_P3];       opb = cos_q[2]; end
      OP_Q4:   begin opa = slot_q[OP_P4];       opb = cos_q[2]; end
      OP_E02:  begin opa = sin_q[1];            opb = sin_q[2]; end
      OP_E12:  begin opa = cos_q[1];            opb = sin_q[2]; end
      OP_E20:  begin opa = sin_q[0];            opb = sin_q[2]; end
      OP_E21:  begin opa = cos_q[0];            opb = sin_q[2]; end
      default: begin opa = '0;                  opb = '0;       end
    endcase
    prod   = opa * opb;
    prod_r = prod + 64'sd536870912;
  end

  // store the rounded Q1.30 product
  always_ff @(posedge clk_i) begin
    if (state_q == MG_MUL) begin
      slot_q[op_q] <= prod_r[61:30];
    end
  end

  // combine products into the matrix
  always_ff @(posedge clk_i) begin
    if (state_q == MG_SUM) begin
      mat_q[0][0] <= 33'(slot_q[OP_P1]) - 33'(slot_q[OP_Q2]);
      mat_q[0][1] <= 33'(slot_q[OP_P3]) + 33'(slot_q[OP_Q4]);
      mat_q[0][2] <= 33'(slot_q[OP_E02]);
      mat_q[1][0] <= -33'(slot_q[OP_P4]) - 33'(slot_q[OP_Q3]);
      mat_q[1][1] <= -33'(slot_q[OP_P2]) + 33'(slot_q[OP_Q1]);
      mat_q[1][2] <= 33'(slot_q[OP_E12]);
      mat_q[2][0] <= 33'(slot_q[OP_E20]);
      mat_q[2][1] <= -33'(slot_q[OP_E21]);
      mat_q[2][2] <= 33'(cos_q[2]);
    end
  end

  // sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= MG_IDLE;
      dirty_q <= 1'b1;
      feed_q  <= '0;
      op_q    <= OP_P1;
    end else begin
      state_q <= state_d;
      dirty_q <= dirty_d;
      feed_q  <= feed_d;
      op_q    <= op_d;
    end
  end

  always_comb begin
    state_d = state_q;
    dirty_d = dirty_q;
    feed_d  = feed_q;
    op_d    = op_q;
    case (state_q)
      MG_IDLE: begin
        if (dirty_q) begin
          dirty_d = 1'b0;
          feed_d  = '0;
          state_d = MG_FEED;
        end
      end
      MG_FEED: begin
        feed_d = feed_q + 2'd1;
        if (feed_q == 2'd2) state_d = MG_WAIT;
      end
      MG_WAIT: begin
        if (chain[TRIG_ITERATIONS].valid && (chain[TRIG_ITERATIONS].sel == 2'd2)) begin
          op_d    = OP_P1;
          state_d = MG_MUL;
        end
      end
      MG_MUL: begin
        if (op_q == OP_E21) state_d = MG_SUM;
        else                op_d = op_e'(op_q + 4'd1);
      end
      MG_SUM: state_d = MG_IDLE;
      default: state_d = MG_IDLE;
    endcase
    if (cfg_we_i) dirty_d = 1'b1;
  end

  assign busy_o   = (state_q != MG_IDLE) || dirty_q;
  assign matrix_o = mat_q;

endmodule

FILE: rtl/core/ofr_rotate_pipe.sv
// Vector times matrix pipeline with rounding, saturation and output skid
module ofr_rotate_pipe #(
  parameter int unsigned DATA_BITS = ofr_pkg::DataBitsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  ofr_pkg::matrix_t            matrix_i,
  input  logic                        hold_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic signed [DATA_BITS-1:0] vec_x_i,
  input  logic signed [DATA_BITS-1:0] vec_y_i,
  input  logic signed [DATA_BITS-1:0] vec_z_i,
  input  logic                        operation_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic signed [DATA_BITS-1:0] out_x_o,
  output logic signed [DATA_BITS-1:0] out_y_o,
  output logic signed [DATA_BITS-1:0] out_z_o,
  output logic                        saturated_o
);
  import ofr_pkg::*;

  localparam int unsigned Nch  = (DATA_BITS + 31) / 32;
  localparam int unsigned Vw   = Nch * 32;
  localparam int unsigned Accw = 33 + Vw;
  localparam int unsigned Sw   = Accw + 2;
  localparam int unsigned Rw   = Sw - 30;
  localparam logic signed [DATA_BITS-1:0] MaxV = {1'b0, {(DATA_BITS-1){1'b1}}};
  localparam logic signed [DATA_BITS-1:0] MinV = {1'b1, {(DATA_BITS-1){1'b0}}};

  logic              en, acc_in;
  logic              v1_q, v2_q, v3_q;
  logic signed [Vw-1:0]   vx [3];
  entry_t                 esel [3][3];
  logic signed [65:0]     pp_q [3][3][Nch];
  logic signed [Accw-1:0] s_d [3][3];
  logic signed [Accw-1:0] s_q [3][3];
  logic signed [Sw-1:0]   acc_q [3];

  logic signed [Rw-1:0]        rr [3];
  logic signed [DATA_BITS-1:0] res [3];
  logic                        sat_any;
  logic [2:0]                  clip;

  logic                        out_valid_q, skid_valid_q, take;
  logic signed [DATA_BITS-1:0] out_q [3];
  logic signed [DATA_BITS-1:0] skid_q [3];
  logic                        out_sat_q, skid_sat_q;

  assign en         = !skid_valid_q;
  assign in_stall_o = skid_valid_q || hold_i;
  assign acc_in     = in_valid_i && !in_stall_o;

  // sign-extend inputs and pick matrix or transpose
  always_comb begin
    vx[0] = Vw'(vec_x_i);
    vx[1] = Vw'(vec_y_i);
    vx[2] = Vw'(vec_z_i);
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        esel[r][k] = operation_i ? matrix_i[k][r] : matrix_i[r][k];
      end
    end
  end

  // partial products, one 33 by 33 multiplier per chunk
  for (genvar r = 0; r < 3; r++) begin : g_row
    for (genvar k = 0; k < 3; k++) begin : g_col
      for (genvar c = 0; c < Nch; c++) begin : g_chunk
        logic signed [32:0] cw;
        if (c == Nch - 1) begin : g_top
          assign cw = {vx[k][32*c+31], vx[k][32*c +: 32]};
        end else begin : g_low
          assign cw = {1'b0, vx[k][32*c +: 32]};
        end
        always_ff @(posedge clk_i) begin
          if (en) pp_q[r][k][c] <= esel[r][k] * cw;
        end
      end
    end
  end

  // join chunks of each product
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        s_d[r][k] = '0;
        for (int c = 0; c < Nch; c++) begin
          s_d[r][k] = s_d[r][k] + (Accw'(pp_q[r][k][c]) <<< (32 * c));
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s_q <= s_d;
      for (int r = 0; r < 3; r++) begin
        acc_q[r] <= Sw'(s_q[r][0]) + Sw'(s_q[r][1]) + Sw'(s_q[r][2])
                    + Sw'(64'sd536870912);
      end
    end
  end

  // advance stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en) begin
      v1_q <= acc_in;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // drop the fraction and saturate
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      rr[r] = acc_q[r][Sw-1:30];
      clip[r] = !((&rr[r][Rw-1:DATA_BITS-1]) || !(|rr[r][Rw-1:DATA_BITS-1]));
      if (!clip[r])          res[r] = rr[r][DATA_BITS-1:0];
      else if (acc_q[r][Sw-1]) res[r] = MinV;
      else                   res[r] = MaxV;
    end
    sat_any = |clip;
  end

  assign take = out_valid_q && !out_stall_i;

  // output register with one skid word behind it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (take) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end
    end else if (v3_q) begin
      if (!out_valid_q || take) out_valid_q <= 1'b1;
      else                      skid_valid_q <= 1'b1;
    end else if (take) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (take) begin
        out_q     <= skid_q;
        out_sat_q <= skid_sat_q;
      end
    end else if (v3_q) begin
      if (!out_valid_q || take) begin
        out_q     <= res;
        out_sat_q <= sat_any;
      end else begin
        skid_q     <= res;
        skid_sat_q <= sat_any;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_x_o     = out_q[0];
  assign out_y_o     = out_q[1];
  assign out_z_o     = out_q[2];
  assign saturated_o = out_sat_q;

endmodule

FILE: rtl/core/ofr_checker.sv
// Port-level checks for the orbital frame rotation, bound to the top level
`include "orbital_frame_rotation_assert.svh"

module ofr_checker #(
  parameter int unsigned DATA_BITS  = ofr_pkg::DataBitsDef
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        cfg_we_i,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic signed [DATA_BITS-1:0] out_x_o,
  input logic signed [DATA_BITS-1:0] out_y_o,
  input logic signed [DATA_BITS-1:0] out_z_o,
  input logic                        saturated_o
);
  localparam logic signed [DATA_BITS-1:0] MaxV = {1'b0, {(DATA_BITS-1){1'b1}}};
  localparam logic signed [DATA_BITS-1:0] MinV = {1'b1, {(DATA_BITS-1){1'b0}}};

  logic clip_seen;

  // any component sitting at a range limit
  assign clip_seen = (out_x_o == MaxV) || (out_x_o == MinV) ||
                     (out_y_o == MaxV) || (out_y_o == MinV) ||
                     (out_z_o == MaxV) || (out_z_o == MinV);

  // a stalled result word stays offered
  `OFR_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o, "result dropped while stalled")

  // a stalled input word stays offered
  `OFR_ASSERT_NEXT(a_in_hold, in_valid_i && in_stall_o, in_valid_i, "input withdrawn while stalled")

  // a register write holds off input while the matrix is rebuilt
  `OFR_ASSERT_NEXT(a_cfg_busy, cfg_we_i, in_stall_o, "input taken during matrix rebuild")

  // a flagged result carries at least one clipped component
  `OFR_ASSERT_NOW(a_sat_clip, out_valid_o && saturated_o, clip_seen, "saturation flag without a clipped component")

endmodule

bind orbital_frame_rotation ofr_checker #(
  .DATA_BITS  (DATA_BITS)
) u_ofr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .cfg_we_i    (cfg_we_i),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_x_o     (out_x_o),
  .out_y_o     (out_y_o),
  .out_z_o     (out_z_o),
  .saturated_o (saturated_o)
);
